[rtl/bmp24_to_rgb565_display_writer_macros.svh]
// ----------------------------------------------------------------------------
// BMP to RGB565 display writer assertion macros
// Immediate-antecedent and next-cycle property wrappers, clocked on clk and
// disabled while rst_n is low. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef BMP24_TO_RGB565_DISPLAY_WRITER_MACROS_SVH
`define BMP24_TO_RGB565_DISPLAY_WRITER_MACROS_SVH
`ifndef SYNTHESIS
`define BMP_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("same-cycle check failed");
`define BMP_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define BMP_ASSERT_IMP(lbl, ant, cons)
`define BMP_ASSERT_NXT(lbl, ant, cons)
`endif
`endif

[rtl/bmp_pkg.sv]
// ----------------------------------------------------------------------------
// BMP to RGB565 display writer package
// Panel geometry, header constants, panel command codes, result kinds and
// the per-byte write plan passed from the parser to the write sequencer.
// ----------------------------------------------------------------------------
package bmp_pkg;

  // Panel and image limits
  localparam int PANEL_WIDTH     = 176;
  localparam int PANEL_HEIGHT    = 132;
  localparam int MAX_IMAGE_WIDTH = 1280;

  // Header layout
  localparam int HDR_LEN   = 34;
  localparam int BIT_COUNT = 24;

  // Field widths
  localparam int CFG_W    = 8;
  localparam int VAL_W    = 16;
  localparam int COL_W    = $clog2(PANEL_WIDTH + 1);
  localparam int ROW_W    = 11;
  localparam int IMG_W_W  = $clog2(MAX_IMAGE_WIDTH + 1);
  localparam int STRIDE_W = $clog2(3 * MAX_IMAGE_WIDTH + 4);

  // Panel commands
  localparam logic [VAL_W-1:0] CMD_CASET = 16'h002A;
  localparam logic [VAL_W-1:0] CMD_PASET = 16'h002B;
  localparam logic [VAL_W-1:0] CMD_RAMWR = 16'h002C;

  // Configuration register indexes
  localparam logic [0:0] REG_COLUMN_OFFSET = 1'b0;
  localparam logic [0:0] REG_ROW_OFFSET    = 1'b1;

  typedef enum logic [2:0] {
    KIND_CMD    = 3'd0,
    KIND_DATA   = 3'd1,
    KIND_DONE   = 3'd2,
    KIND_REJECT = 3'd3,
    KIND_TRUNC  = 3'd4
  } kind_t;

  // Everything one file byte asks of the panel bus
  typedef struct packed {
    logic              win;
    logic              has_data;
    logic              has_status;
    kind_t             status_kind;
    logic [VAL_W-1:0]  col_start;
    logic [VAL_W-1:0]  col_end;
    logic [VAL_W-1:0]  row_addr;
    logic [VAL_W-1:0]  data_word;
  } plan_t;

endpackage

[rtl/bmp24_to_rgb565_display_writer.sv]
// ----------------------------------------------------------------------------
// BMP 24-bit to RGB565 display writer
// Parses a 24-bit BMP byte stream and turns it into panel window commands
// and RGB565 pixel writes, with done, rejected and truncated status.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one file byte per transfer, in file order, with
//   in_end_of_file on the last byte. The result channel carries panel writes
//   (command or data) and status words; out_last marks the final write caused
//   by one file byte. cfg_write_en with cfg_index/cfg_data sets the column and
//   row window offsets; write them only while the block is idle.
//   A byte is held in the input register and then decoded; its plan is loaded
//   into the write sequencer's plan register, from which its first write is
//   offered on the result channel.
//   A byte with no write is taken without loading the sequencer; a byte that
//   opens a displayed row causes up to twelve writes, as the write sequencer
//   sends one panel write per cycle while out_ready is high. The next byte is
//   decoded in the same cycle the previous byte's last write transfers.
//   Reset clears the parser to the header phase and both offsets to zero.
//   When out_ready is low the current write holds and the block stops taking
//   bytes once its input register is full; nothing is dropped.
// ----------------------------------------------------------------------------
module bmp24_to_rgb565_display_writer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_file_byte,
  input  logic                       in_end_of_file,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_kind,
  output logic [bmp_pkg::VAL_W-1:0]  out_value,
  output logic                       out_last,
  input  logic                       cfg_write_en,
  input  logic [0:0]                 cfg_index,
  input  logic [bmp_pkg::CFG_W-1:0]  cfg_data
);
  import bmp_pkg::*;

  logic             in_valid_r;
  logic [7:0]       in_byte_r;
  logic             in_eof_r;
  logic [CFG_W-1:0] column_offset_r;
  logic [CFG_W-1:0] row_offset_r;
  logic             take;
  logic             load;
  logic             emit_free;
  plan_t            plan;
  kind_t            kind;

  assign take     = in_valid_r && emit_free;
  assign load     = take && (plan.win | plan.has_data | plan.has_status);
  assign in_ready = !in_valid_r || take;
  assign out_kind = kind;

  // Hold the incoming byte until the decoder takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_file_byte;
      in_eof_r  <= in_end_of_file;
    end
  end

  // Window offset registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_offset_r <= '0;
      row_offset_r    <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_COLUMN_OFFSET: column_offset_r <= cfg_data;
        REG_ROW_OFFSET:    row_offset_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bmp_parse u_parse (
    .clk             (clk),
    .rst_n           (rst_n),
    .take_i          (take),
    .byte_i          (in_byte_r),
    .eof_i           (in_eof_r),
    .column_offset_i (column_offset_r),
    .row_offset_i    (row_offset_r),
    .plan_o          (plan)
  );

  bmp_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (load),
    .plan_i      (plan),
    .free_o      (emit_free),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_kind_o  (kind),
    .out_value_o (out_value),
    .out_last_o  (out_last)
  );

endmodule

[rtl/bmp_parse.sv]
// ----------------------------------------------------------------------------
// BMP stream parser
// Walks the file one byte per transfer: captures the header, checks it,
// skips cropped rows and row padding, packs BGR into RGB565 and builds the
// write plan for each byte. State advances on every byte taken.
// ----------------------------------------------------------------------------
`include "bmp24_to_rgb565_display_writer_macros.svh"

module bmp_parse (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       take_i,
  input  logic [7:0]                 byte_i,
  input  logic                       eof_i,
  input  logic [bmp_pkg::CFG_W-1:0]  column_offset_i,
  input  logic [bmp_pkg::CFG_W-1:0]  row_offset_i,
  output bmp_pkg::plan_t             plan_o
);
  import bmp_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_FINISHED
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [31:0]         pos_r, pos_nxt;
  logic [31:0]         offset_r, offset_nxt;
  logic [31:0]         width_r, width_nxt;
  logic [31:0]         height_r, height_nxt;
  logic                hdr_bad_r, hdr_bad_nxt;
  logic [31:0]         skip_r, skip_nxt;
  logic [STRIDE_W-1:0] idx_r, idx_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [10:0]         acc_r, acc_nxt;
  logic [1:0]          bph_r, bph_nxt;
  logic [COL_W-1:0]    cols_r, cols_nxt;

  // Geometry derived from the captured header
  logic                wide, tall;
  logic [31:0]         wdiff, hdiff;
  logic [IMG_W_W-1:0]  img_w;
  logic [COL_W-1:0]    shown_w, xs, xe;
  logic [ROW_W-1:0]    shown_h, ystart, row_top;
  logic [STRIDE_W-1:0] st3, stride;

  assign wide    = width_r > 32'(PANEL_WIDTH);
  assign tall    = height_r > 32'(PANEL_HEIGHT);
  assign wdiff   = 32'(PANEL_WIDTH) - width_r;
  assign hdiff   = 32'(PANEL_HEIGHT) - height_r;
  assign img_w   = width_r[IMG_W_W-1:0];
  assign shown_w = wide ? COL_W'(PANEL_WIDTH) : width_r[COL_W-1:0];
  assign xs      = wide ? '0 : wdiff[COL_W:1];
  assign xe      = COL_W'(xs + shown_w - COL_W'(1));
  assign shown_h = tall ? ROW_W'(PANEL_HEIGHT) : height_r[ROW_W-1:0];
  assign ystart  = tall ? '0 : hdiff[ROW_W:1];
  assign row_top = ROW_W'(ystart + shown_h - ROW_W'(1));
  assign st3     = STRIDE_W'({img_w, 1'b0}) + STRIDE_W'(img_w) + STRIDE_W'(3);
  assign stride  = {st3[STRIDE_W-1:2], 2'b00};

  logic [1:0]          lane;
  logic [7:0]          want_byte;
  logic                hdr_fail;
  logic                pix;
  logic                done;
  logic [STRIDE_W-1:0] idx_inc;
  logic                row_end;
  logic [COL_W-1:0]    cols_inc;

  assign lane     = pos_r[1:0] - 2'd2;
  assign idx_inc  = idx_r + STRIDE_W'(1);
  assign row_end  = idx_inc >= stride;
  assign cols_inc = cols_r + COL_W'(1);

  // Work out the next state and the plan for the byte in hand
  always_comb begin
    phase_nxt   = phase_r;
    offset_nxt  = offset_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    hdr_bad_nxt = hdr_bad_r;
    skip_nxt    = skip_r;
    idx_nxt     = idx_r;
    row_nxt     = row_r;
    acc_nxt     = acc_r;
    bph_nxt     = bph_r;
    cols_nxt    = cols_r;
    pos_nxt     = (pos_r != '1) ? pos_r + 32'd1 : pos_r;
    plan_o.win         = 1'b0;
    plan_o.has_data    = 1'b0;
    plan_o.has_status  = 1'b0;
    plan_o.status_kind = KIND_DONE;
    plan_o.data_word   = '0;
    // Window addresses for the row being opened
    plan_o.col_start   = VAL_W'(column_offset_i) + VAL_W'(xs);
    plan_o.col_end     = VAL_W'(column_offset_i) + VAL_W'(xe);
    plan_o.row_addr    = VAL_W'(row_offset_i) + VAL_W'(row_r);
    pix         = 1'b0;
    done        = 1'b0;
    hdr_fail    = 1'b0;
    want_byte   = 8'd0;

    unique case (phase_r)
      PH_HEADER: begin
        // Little-endian capture of offset, width and height
        if (pos_r >= 32'd10 && pos_r <= 32'd13) begin
          offset_nxt[{lane, 3'b000} +: 8] = byte_i;
        end else if (pos_r >= 32'd18 && pos_r <= 32'd21) begin
          width_nxt[{lane, 3'b000} +: 8] = byte_i;
        end else if (pos_r >= 32'd22 && pos_r <= 32'd25) begin
          height_nxt[{lane, 3'b000} +: 8] = byte_i;
        end
        // Planes, bit count and compression must match byte for byte
        if (pos_r >= 32'd26) begin
          if (pos_r == 32'd26) begin
            want_byte = 8'd1;
          end else if (pos_r == 32'd28) begin
            want_byte = 8'(BIT_COUNT);
          end else if (pos_r == 32'd29) begin
            want_byte = 8'(BIT_COUNT >> 8);
          end
          hdr_bad_nxt = hdr_bad_r | (byte_i != want_byte);
        end
        if (pos_r == 32'(HDR_LEN - 1)) begin
          hdr_fail = hdr_bad_nxt || (width_r == '0) ||
                     (width_r > 32'(MAX_IMAGE_WIDTH)) || (height_r == '0) ||
                     (offset_r < 32'(HDR_LEN));
          if (hdr_fail) begin
            phase_nxt          = PH_FINISHED;
            plan_o.has_status  = 1'b1;
            plan_o.status_kind = KIND_REJECT;
          end else begin
            skip_nxt  = tall ? height_r - 32'(PANEL_HEIGHT) : '0;
            row_nxt   = row_top;
            idx_nxt   = '0;
            cols_nxt  = '0;
            bph_nxt   = 2'd0;
            acc_nxt   = '0;
            phase_nxt = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (pos_r >= offset_r) begin
          phase_nxt = PH_PIXELS;
          pix       = 1'b1;
        end
      end
      PH_PIXELS: begin
        pix = 1'b1;
      end
      PH_FINISHED: begin
      end
      default: begin
      end
    endcase

    if (pix) begin
      if (skip_r != '0) begin
        // Drop a cropped bottom row
        idx_nxt = row_end ? '0 : idx_inc;
        if (row_end) begin
          skip_nxt = skip_r - 32'd1;
        end
      end else begin
        plan_o.win = (idx_r == '0);
        if (cols_r < shown_w) begin
          unique case (bph_r)
            2'd0: begin
              acc_nxt = {6'd0, byte_i[7:3]};
              bph_nxt = 2'd1;
            end
            2'd1: begin
              acc_nxt = {byte_i[7:2], acc_r[4:0]};
              bph_nxt = 2'd2;
            end
            default: begin
              plan_o.has_data  = 1'b1;
              plan_o.data_word = {byte_i[7:3], acc_r};
              acc_nxt          = acc_r;
              cols_nxt         = cols_inc;
              bph_nxt          = 2'd0;
              if (cols_inc == shown_w && row_r == ystart) begin
                done               = 1'b1;
                phase_nxt          = PH_FINISHED;
                plan_o.has_status  = 1'b1;
                plan_o.status_kind = KIND_DONE;
              end
            end
          endcase
        end
        // Advance through the row, padding included
        if (!done) begin
          idx_nxt = idx_inc;
          if (row_end) begin
            idx_nxt  = '0;
            cols_nxt = '0;
            bph_nxt  = 2'd0;
            row_nxt  = row_r - ROW_W'(1);
          end
        end
      end
    end

    // Close the file: report a reject or truncation if unfinished, return to the header phase
    if (eof_i) begin
      if (phase_nxt == PH_HEADER) begin
        plan_o.has_status  = 1'b1;
        plan_o.status_kind = KIND_REJECT;
      end else if (phase_nxt == PH_SKIP || phase_nxt == PH_PIXELS) begin
        plan_o.has_status  = 1'b1;
        plan_o.status_kind = KIND_TRUNC;
      end
      phase_nxt   = PH_HEADER;
      pos_nxt     = '0;
      offset_nxt  = '0;
      width_nxt   = '0;
      height_nxt  = '0;
      hdr_bad_nxt = 1'b0;
      skip_nxt    = '0;
      idx_nxt     = '0;
      row_nxt     = '0;
      acc_nxt     = '0;
      bph_nxt     = 2'd0;
      cols_nxt    = '0;
    end
  end

  // Hold parser state; advance on each byte taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      pos_r     <= '0;
      offset_r  <= '0;
      width_r   <= '0;
      height_r  <= '0;
      hdr_bad_r <= 1'b0;
      skip_r    <= '0;
      idx_r     <= '0;
      row_r     <= '0;
      acc_r     <= '0;
      bph_r     <= 2'd0;
      cols_r    <= '0;
    end else if (take_i) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      offset_r  <= offset_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      hdr_bad_r <= hdr_bad_nxt;
      skip_r    <= skip_nxt;
      idx_r     <= idx_nxt;
      row_r     <= row_nxt;
      acc_r     <= acc_nxt;
      bph_r     <= bph_nxt;
      cols_r    <= cols_nxt;
    end
  end

  `BMP_ASSERT_IMP(a_hdr_pos, phase_r == PH_HEADER, pos_r < 32'(HDR_LEN))
  `BMP_ASSERT_IMP(a_cols_bound, phase_r == PH_PIXELS, cols_r <= shown_w)
  `BMP_ASSERT_IMP(a_bph_range, phase_r == PH_PIXELS, bph_r != 2'd3)

endmodule

[rtl/bmp_emit.sv]
// ----------------------------------------------------------------------------
// Panel write sequencer
// Holds the plan of one byte and plays it out one panel write per transfer:
// the row window burst, then the pixel word, then the status.
// ----------------------------------------------------------------------------
`include "bmp24_to_rgb565_display_writer_macros.svh"

module bmp_emit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load_i,
  input  bmp_pkg::plan_t             plan_i,
  output logic                       free_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output bmp_pkg::kind_t             out_kind_o,
  output logic [bmp_pkg::VAL_W-1:0]  out_value_o,
  output logic                       out_last_o
);
  import bmp_pkg::*;

  typedef enum logic [3:0] {
    SLOT_CASET,
    SLOT_XS_HI,
    SLOT_XS_LO,
    SLOT_XE_HI,
    SLOT_XE_LO,
    SLOT_PASET,
    SLOT_YS_HI,
    SLOT_YS_LO,
    SLOT_YE_HI,
    SLOT_YE_LO,
    SLOT_RAMWR,
    SLOT_PIXEL,
    SLOT_STATUS
  } slot_t;

  logic  busy_r;
  slot_t slot_r;
  plan_t plan_r;
  slot_t next_slot;
  slot_t first_slot;
  logic  has_next;

  // Decode the current write and the one after it
  always_comb begin
    out_kind_o  = KIND_DATA;
    out_value_o = '0;
    next_slot   = SLOT_STATUS;
    has_next    = 1'b1;
    unique case (slot_r)
      SLOT_CASET: begin
        out_kind_o  = KIND_CMD;
        out_value_o = CMD_CASET;
        next_slot   = SLOT_XS_HI;
      end
      SLOT_XS_HI: next_slot = SLOT_XS_LO;
      SLOT_XS_LO: begin
        out_value_o = plan_r.col_start;
        next_slot   = SLOT_XE_HI;
      end
      SLOT_XE_HI: next_slot = SLOT_XE_LO;
      SLOT_XE_LO: begin
        out_value_o = plan_r.col_end;
        next_slot   = SLOT_PASET;
      end
      SLOT_PASET: begin
        out_kind_o  = KIND_CMD;
        out_value_o = CMD_PASET;
        next_slot   = SLOT_YS_HI;
      end
      SLOT_YS_HI: next_slot = SLOT_YS_LO;
      SLOT_YS_LO: begin
        out_value_o = plan_r.row_addr;
        next_slot   = SLOT_YE_HI;
      end
      SLOT_YE_HI: next_slot = SLOT_YE_LO;
      SLOT_YE_LO: begin
        out_value_o = plan_r.row_addr;
        next_slot   = SLOT_RAMWR;
      end
      SLOT_RAMWR: begin
        out_kind_o  = KIND_CMD;
        out_value_o = CMD_RAMWR;
        next_slot   = plan_r.has_data ? SLOT_PIXEL : SLOT_STATUS;
        has_next    = plan_r.has_data | plan_r.has_status;
      end
      SLOT_PIXEL: begin
        out_value_o = plan_r.data_word;
        has_next    = plan_r.has_status;
      end
      SLOT_STATUS: begin
        out_kind_o = plan_r.status_kind;
        has_next   = 1'b0;
      end
      default: begin
        has_next = 1'b0;
      end
    endcase
  end

  assign first_slot  = plan_i.win ? SLOT_CASET :
                       (plan_i.has_data ? SLOT_PIXEL : SLOT_STATUS);
  assign out_valid_o = busy_r;
  assign out_last_o  = !has_next;
  assign free_o      = !busy_r || (out_ready_i && !has_next);

  // Track whether a plan is still being played out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (load_i) begin
      busy_r <= 1'b1;
    end else if (busy_r && out_ready_i && !has_next) begin
      busy_r <= 1'b0;
    end
  end

  // Hold the plan and step through its writes
  always_ff @(posedge clk) begin
    if (load_i) begin
      plan_r <= plan_i;
      slot_r <= first_slot;
    end else if (busy_r && out_ready_i && has_next) begin
      slot_r <= next_slot;
    end
  end

  `BMP_ASSERT_IMP(a_load_free, load_i, free_o)
  `BMP_ASSERT_NXT(a_stall_hold, busy_r && !out_ready_i, busy_r && slot_r == $past(slot_r))
  `BMP_ASSERT_IMP(a_status_last, busy_r && slot_r == SLOT_STATUS, out_last_o)

endmodule
